[src/mfas_pkg.sv]
// Package for the max-flow augmenting search block.
// Holds sizes, status, register and input mode codes, and the packed records of the edge
// table and the search stack. No dependencies.
package mfas_pkg;

  localparam int MAX_EDGES = 64;
  localparam int IDX_W     = $clog2(MAX_EDGES);
  localparam int CNT_W     = $clog2(MAX_EDGES + 1);
  localparam int NODE_W    = 16;
  localparam int CAP_W     = 16;
  localparam int SUM_W     = 22;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_W     = 16;

  localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};

  // Result status codes
  localparam logic [1:0] ST_ADDED = 2'd0;
  localparam logic [1:0] ST_DUP   = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;
  localparam logic [1:0] ST_FLOW  = 2'd3;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SOURCE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SINK   = 2'd1;

  // Input mode codes
  localparam logic MODE_ADD   = 1'b0;
  localparam logic MODE_SOLVE = 1'b1;

  // One edge table word
  typedef struct packed {
    logic [NODE_W-1:0] tail;
    logic [NODE_W-1:0] head;
    logic [CAP_W-1:0]  cap;
  } edge_t;

  // One search stack frame: node, edge taken out of it, backward flag
  typedef struct packed {
    logic [NODE_W-1:0] at;
    logic [IDX_W-1:0]  eidx;
    logic              bwd;
  } frame_t;

endpackage

[src/max_flow_augmenting_search_top.sv]
// Max-flow block: edge table load and depth-first augmenting search solve.
// A load compares the new edge with each stored edge, then appends it; a solve zeroes
// flows, checks each visited node for a direct edge to the sink before scanning its edges,
// applies each augmentation, then reports every edge. One item at a time; input stalls
// until its last result transfers. Edge and flow reads share one read address.
// Reset clears the edge count, marks and control registers; source 0, sink 1.
module max_flow_augmenting_search_top
  import mfas_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_data_i,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic                 mode_i,
  input  logic [NODE_W-1:0]    from_node_i,
  input  logic [NODE_W-1:0]    to_node_i,
  input  logic [CAP_W-1:0]     edge_capacity_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [1:0]           status_o,
  output logic [NODE_W-1:0]    report_from_o,
  output logic [NODE_W-1:0]    report_to_o,
  output logic [CAP_W-1:0]     report_capacity_o,
  output logic [CAP_W-1:0]     report_flow_o,
  output logic [SUM_W-1:0]     total_flow_o,
  output logic                 edge_present_o,
  output logic                 last_o
);

  // Sequencer states
  localparam logic [4:0] S_IDLE    = 5'd0;
  localparam logic [4:0] S_LD_RD   = 5'd1;
  localparam logic [4:0] S_LD_CMP  = 5'd2;
  localparam logic [4:0] S_EX_RD   = 5'd3;
  localparam logic [4:0] S_EX_CMP  = 5'd4;
  localparam logic [4:0] S_DR_RD   = 5'd5;
  localparam logic [4:0] S_DR_CMP  = 5'd6;
  localparam logic [4:0] S_SC_RD   = 5'd7;
  localparam logic [4:0] S_SC_EVAL = 5'd8;
  localparam logic [4:0] S_POP     = 5'd9;
  localparam logic [4:0] S_BN_STK  = 5'd10;
  localparam logic [4:0] S_BN_EDGE = 5'd11;
  localparam logic [4:0] S_BN_EVAL = 5'd12;
  localparam logic [4:0] S_UD_RD   = 5'd13;
  localparam logic [4:0] S_UD_WR   = 5'd14;
  localparam logic [4:0] S_UF_STK  = 5'd15;
  localparam logic [4:0] S_UF_RD   = 5'd16;
  localparam logic [4:0] S_UF_WR   = 5'd17;
  localparam logic [4:0] S_SUM     = 5'd18;
  localparam logic [4:0] S_RP_RD   = 5'd19;
  localparam logic [4:0] S_RP_EMIT = 5'd20;
  localparam logic [4:0] S_OUT     = 5'd21;

  // Memories
  edge_t             edge_mem [MAX_EDGES];
  logic [CAP_W-1:0]  flow_mem [MAX_EDGES];
  frame_t            stk_mem  [MAX_EDGES];

  edge_t             rd_edge_q;
  logic [CAP_W-1:0]  rd_flow_q;
  frame_t            stk_rd_q;

  logic              em_re, em_we, fm_we, sk_re, sk_we;
  logic [IDX_W-1:0]  em_raddr, em_waddr, fm_waddr, sk_raddr, sk_waddr;
  edge_t             em_wdata;
  logic [CAP_W-1:0]  fm_wdata;
  frame_t            sk_wdata;

  // Control and datapath registers
  logic [4:0]        state_q, state_d;
  logic [CNT_W-1:0]  total_q, total_d;
  logic [CNT_W-1:0]  idx_q, idx_d;
  logic [CNT_W-1:0]  e_q, e_d;
  logic              ph_q, ph_d;
  logic [NODE_W-1:0] at_q, at_d;
  logic [CNT_W-1:0]  depth_q, depth_d;
  logic [IDX_W-1:0]  dir_q, dir_d;
  logic [CAP_W-1:0]  k_q, k_d;
  logic [SUM_W-1:0]  sum_q, sum_d;
  logic              src_ok_q, src_ok_d, snk_ok_q, snk_ok_d;
  logic [MAX_EDGES-1:0] vis_q, vis_d;
  logic [NODE_W-1:0] source_q, sink_q;
  edge_t             ld_q, ld_d;

  logic              ov_q, ov_d;
  logic [1:0]        ost_q, ost_d;
  edge_t             orep_q, orep_d;
  logic [CAP_W-1:0]  oflow_q, oflow_d;
  logic [SUM_W-1:0]  otot_q, otot_d;
  logic              opres_q, opres_d, olast_q, olast_d;

  logic [CAP_W-1:0]  resid, r_val;
  logic [SUM_W:0]    sum_ext;

  assign resid   = rd_edge_q.cap - rd_flow_q;
  assign r_val   = stk_rd_q.bwd ? rd_flow_q : resid;
  assign sum_ext = {1'b0, sum_q} + {{(SUM_W+1-CAP_W){1'b0}}, k_q};

  // Memory ports
  always_ff @(posedge clk_i) begin
    if (em_we) edge_mem[em_waddr] <= em_wdata;
    if (fm_we) flow_mem[fm_waddr] <= fm_wdata;
    if (em_re) begin
      rd_edge_q <= edge_mem[em_raddr];
      rd_flow_q <= flow_mem[em_raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (sk_we) stk_mem[sk_waddr] <= sk_wdata;
    if (sk_re) stk_rd_q <= stk_mem[sk_raddr];
  end

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      source_q <= '0;
      sink_q   <= NODE_W'(1);
    end else if (cfg_we_i) begin
      if (cfg_idx_i == REG_SOURCE) source_q <= cfg_data_i[NODE_W-1:0];
      if (cfg_idx_i == REG_SINK)   sink_q   <= cfg_data_i[NODE_W-1:0];
    end
  end

  // Sequencer
  always_comb begin
    state_d  = state_q;
    total_d  = total_q;
    idx_d    = idx_q;
    e_d      = e_q;
    ph_d     = ph_q;
    at_d     = at_q;
    depth_d  = depth_q;
    dir_d    = dir_q;
    k_d      = k_q;
    sum_d    = sum_q;
    src_ok_d = src_ok_q;
    snk_ok_d = snk_ok_q;
    vis_d    = vis_q;
    ld_d     = ld_q;
    ov_d     = ov_q;
    ost_d    = ost_q;
    orep_d   = orep_q;
    oflow_d  = oflow_q;
    otot_d   = otot_q;
    opres_d  = opres_q;
    olast_d  = olast_q;
    em_re    = 1'b0;
    em_raddr = idx_q[IDX_W-1:0];
    em_we    = 1'b0;
    em_waddr = total_q[IDX_W-1:0];
    em_wdata = ld_q;
    fm_we    = 1'b0;
    fm_waddr = idx_q[IDX_W-1:0];
    fm_wdata = '0;
    sk_re    = 1'b0;
    sk_raddr = idx_q[IDX_W-1:0];
    sk_we    = 1'b0;
    sk_waddr = depth_q[IDX_W-1:0];
    sk_wdata = '{at: at_q, eidx: e_q[IDX_W-1:0], bwd: ph_q};

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          idx_d = '0;
          if (mode_i == MODE_ADD) begin
            ld_d    = '{tail: from_node_i, head: to_node_i, cap: edge_capacity_i};
            state_d = S_LD_RD;
          end else begin
            sum_d    = '0;
            src_ok_d = 1'b0;
            snk_ok_d = 1'b0;
            if (total_q == '0) begin
              // empty table: one bare report
              ov_d    = 1'b1;
              ost_d   = ST_FLOW;
              orep_d  = '0;
              oflow_d = '0;
              otot_d  = '0;
              opres_d = 1'b0;
              olast_d = 1'b1;
              state_d = S_OUT;
            end else begin
              state_d = S_EX_RD;
            end
          end
        end
      end

      // Load: duplicate scan, then append unless the table is full
      S_LD_RD: begin
        if (idx_q == total_q) begin
          ov_d    = 1'b1;
          olast_d = 1'b1;
          otot_d  = '0;
          oflow_d = '0;
          state_d = S_OUT;
          if (total_q == CNT_W'(MAX_EDGES)) begin
            ost_d   = ST_FULL;
            orep_d  = '0;
            opres_d = 1'b0;
          end else begin
            em_we    = 1'b1;
            fm_we    = 1'b1;
            fm_waddr = total_q[IDX_W-1:0];
            total_d  = total_q + 1'b1;
            ost_d    = ST_ADDED;
            orep_d   = ld_q;
            opres_d  = 1'b1;
          end
        end else begin
          em_re   = 1'b1;
          state_d = S_LD_CMP;
        end
      end

      S_LD_CMP: begin
        if (rd_edge_q.tail == ld_q.tail && rd_edge_q.head == ld_q.head) begin
          ov_d    = 1'b1;
          ost_d   = ST_DUP;
          orep_d  = rd_edge_q;
          oflow_d = rd_flow_q;
          otot_d  = '0;
          opres_d = 1'b1;
          olast_d = 1'b1;
          state_d = S_OUT;
        end else begin
          idx_d   = idx_q + 1'b1;
          state_d = S_LD_RD;
        end
      end

      // Solve setup: zero flows, check source and sink exist
      S_EX_RD: begin
        if (idx_q == total_q) begin
          idx_d = '0;
          if (src_ok_q && snk_ok_q) begin
            vis_d   = '0;
            depth_d = '0;
            at_d    = source_q;
            state_d = S_DR_RD;
          end else begin
            state_d = S_RP_RD;
          end
        end else begin
          em_re   = 1'b1;
          state_d = S_EX_CMP;
        end
      end

      S_EX_CMP: begin
        fm_we = 1'b1;
        if (rd_edge_q.tail == source_q || rd_edge_q.head == source_q) src_ok_d = 1'b1;
        if (rd_edge_q.tail == sink_q || rd_edge_q.head == sink_q)     snk_ok_d = 1'b1;
        idx_d   = idx_q + 1'b1;
        state_d = S_EX_RD;
      end

      // Direct edge to sink from the current node
      S_DR_RD: begin
        if (idx_q == total_q) begin
          e_d     = '0;
          ph_d    = 1'b0;
          state_d = S_SC_RD;
        end else begin
          em_re   = 1'b1;
          state_d = S_DR_CMP;
        end
      end

      S_DR_CMP: begin
        if (rd_edge_q.tail == at_q && rd_edge_q.head == sink_q &&
            rd_flow_q < rd_edge_q.cap) begin
          dir_d   = idx_q[IDX_W-1:0];
          k_d     = resid;
          idx_d   = '0;
          state_d = S_BN_STK;
        end else begin
          idx_d   = idx_q + 1'b1;
          state_d = S_DR_RD;
        end
      end

      // Scan edges touching the node; marked edges are skipped in the forward phase only
      S_SC_RD: begin
        if (e_q == total_q) begin
          if (depth_q == '0) begin
            idx_d   = '0;
            state_d = S_RP_RD;
          end else begin
            sk_re    = 1'b1;
            sk_raddr = IDX_W'(depth_q - 1'b1);
            state_d  = S_POP;
          end
        end else if (!ph_q && vis_q[e_q[IDX_W-1:0]]) begin
          e_d = e_q + 1'b1;
        end else begin
          em_re    = 1'b1;
          em_raddr = e_q[IDX_W-1:0];
          state_d  = S_SC_EVAL;
        end
      end

      S_SC_EVAL: begin
        state_d = S_SC_RD;
        if (!ph_q) begin
          ph_d = 1'b1;
          if (rd_edge_q.tail == at_q) begin
            vis_d[e_q[IDX_W-1:0]] = 1'b1;
            if (rd_flow_q < rd_edge_q.cap) begin
              sk_we   = 1'b1;
              depth_d = depth_q + 1'b1;
              at_d    = rd_edge_q.head;
              idx_d   = '0;
              state_d = S_DR_RD;
            end
          end
        end else begin
          ph_d = 1'b0;
          e_d  = e_q + 1'b1;
          if (rd_edge_q.head == at_q) begin
            vis_d[e_q[IDX_W-1:0]] = 1'b1;
            if (rd_flow_q != '0) begin
              sk_we   = 1'b1;
              depth_d = depth_q + 1'b1;
              at_d    = rd_edge_q.tail;
              idx_d   = '0;
              e_d     = e_q;
              ph_d    = 1'b1;
              state_d = S_DR_RD;
            end
          end
        end
      end

      // Return to the parent node and resume its scan
      S_POP: begin
        at_d    = stk_rd_q.at;
        depth_d = depth_q - 1'b1;
        if (!stk_rd_q.bwd) begin
          e_d  = CNT_W'(stk_rd_q.eidx);
          ph_d = 1'b1;
        end else begin
          e_d  = CNT_W'(stk_rd_q.eidx) + 1'b1;
          ph_d = 1'b0;
        end
        state_d = S_SC_RD;
      end

      // Bottleneck over the path frames; the direct edge counts once
      S_BN_STK: begin
        if (idx_q == depth_q) begin
          state_d = S_UD_RD;
        end else begin
          sk_re   = 1'b1;
          state_d = S_BN_EDGE;
        end
      end

      S_BN_EDGE: begin
        em_re    = 1'b1;
        em_raddr = stk_rd_q.eidx;
        state_d  = S_BN_EVAL;
      end

      S_BN_EVAL: begin
        if (stk_rd_q.eidx != dir_q && r_val < k_q) k_d = r_val;
        idx_d   = idx_q + 1'b1;
        state_d = S_BN_STK;
      end

      // Apply the bottleneck: direct edge, then path frames
      S_UD_RD: begin
        em_re    = 1'b1;
        em_raddr = dir_q;
        state_d  = S_UD_WR;
      end

      S_UD_WR: begin
        fm_we    = 1'b1;
        fm_waddr = dir_q;
        fm_wdata = rd_flow_q + k_q;
        idx_d    = '0;
        state_d  = S_UF_STK;
      end

      S_UF_STK: begin
        if (idx_q == depth_q) begin
          state_d = S_SUM;
        end else begin
          sk_re   = 1'b1;
          state_d = S_UF_RD;
        end
      end

      S_UF_RD: begin
        em_re    = 1'b1;
        em_raddr = stk_rd_q.eidx;
        state_d  = S_UF_WR;
      end

      S_UF_WR: begin
        if (stk_rd_q.eidx != dir_q) begin
          fm_we    = 1'b1;
          fm_waddr = stk_rd_q.eidx;
          fm_wdata = stk_rd_q.bwd ? (rd_flow_q - k_q) : (rd_flow_q + k_q);
        end
        idx_d   = idx_q + 1'b1;
        state_d = S_UF_STK;
      end

      // Accumulate; saturation ends the solve
      S_SUM: begin
        idx_d = '0;
        if (sum_ext >= {1'b0, SUM_MAX}) begin
          sum_d   = SUM_MAX;
          state_d = S_RP_RD;
        end else begin
          sum_d   = sum_ext[SUM_W-1:0];
          vis_d   = '0;
          depth_d = '0;
          at_d    = source_q;
          state_d = S_DR_RD;
        end
      end

      // Flow report, one edge per transfer
      S_RP_RD: begin
        em_re   = 1'b1;
        state_d = S_RP_EMIT;
      end

      S_RP_EMIT: begin
        ov_d    = 1'b1;
        ost_d   = ST_FLOW;
        orep_d  = rd_edge_q;
        oflow_d = rd_flow_q;
        otot_d  = sum_q;
        opres_d = 1'b1;
        olast_d = (idx_q == total_q - 1'b1);
        state_d = S_OUT;
      end

      S_OUT: begin
        if (!out_stall_i) begin
          ov_d = 1'b0;
          if (olast_q) begin
            state_d = S_IDLE;
          end else begin
            idx_d   = idx_q + 1'b1;
            state_d = S_RP_RD;
          end
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      total_q  <= '0;
      idx_q    <= '0;
      e_q      <= '0;
      ph_q     <= 1'b0;
      depth_q  <= '0;
      sum_q    <= '0;
      src_ok_q <= 1'b0;
      snk_ok_q <= 1'b0;
      vis_q    <= '0;
      ov_q     <= 1'b0;
    end else begin
      state_q  <= state_d;
      total_q  <= total_d;
      idx_q    <= idx_d;
      e_q      <= e_d;
      ph_q     <= ph_d;
      depth_q  <= depth_d;
      sum_q    <= sum_d;
      src_ok_q <= src_ok_d;
      snk_ok_q <= snk_ok_d;
      vis_q    <= vis_d;
      ov_q     <= ov_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    at_q    <= at_d;
    dir_q   <= dir_d;
    k_q     <= k_d;
    ld_q    <= ld_d;
    ost_q   <= ost_d;
    orep_q  <= orep_d;
    oflow_q <= oflow_d;
    otot_q  <= otot_d;
    opres_q <= opres_d;
    olast_q <= olast_d;
  end

  assign in_stall_o        = (state_q != S_IDLE);
  assign out_valid_o       = ov_q;
  assign status_o          = ost_q;
  assign report_from_o     = orep_q.tail;
  assign report_to_o       = orep_q.head;
  assign report_capacity_o = orep_q.cap;
  assign report_flow_o     = oflow_q;
  assign total_flow_o      = otot_q;
  assign edge_present_o    = opres_q;
  assign last_o            = olast_q;

`ifndef NO_ASSERTIONS
  a_idle_no_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_stall_o |-> !out_valid_o) else $error("result pending while idle");
  a_depth_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    depth_q <= CNT_W'(MAX_EDGES) && total_q <= CNT_W'(MAX_EDGES))
    else $error("stack depth or edge count out of range");
  a_load_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != ST_FLOW |-> last_o) else $error("load result not last");
  a_total_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !edge_present_o |-> total_flow_o == '0)
    else $error("empty result carries flow");
`endif

endmodule
